@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file cso_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ rtl/cso_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cso_pkg
// Types, sizes, codes and the arrow sprite shared by the cursor overlay block.
// ----------------------------------------------------------------------------
package cso_pkg;

    // Frame and sprite geometry
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int SPRITE_W    = 12;
    localparam int SPRITE_H    = 19;
    localparam int CELLS       = SPRITE_W * SPRITE_H;
    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
    localparam int PATCH_AW    = $clog2(CELLS);
    localparam int XW          = $clog2(MAX_WIDTH);
    localparam int YW          = $clog2(MAX_HEIGHT);
    localparam int COL_W       = $clog2(SPRITE_W);
    localparam int ROW_W       = $clog2(SPRITE_H);

    // Field widths
    localparam int DIM_W      = 9;
    localparam int PIX_W      = 32;
    localparam int COORD_W    = 16;
    localparam int WALK_W     = COORD_W + 1;
    localparam int CFG_IDX_W  = 2;

    localparam logic [PIX_W-1:0] BORDER_COLOR = 32'h0000_0000;
    localparam logic [PIX_W-1:0] FILL_RESET   = 32'hFFFF_FFFF;
    localparam logic [DIM_W-1:0] DIM_RESET    = 9'd256;

    // Request codes
    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_READ   = 2'd1,
        REQ_MOVE   = 2'd2,
        REQ_FORGET = 2'd3
    } t_req_kind;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_FILL   = 2'd2
    } t_cfg_reg;

    // Sprite cell codes
    typedef enum logic [1:0] {
        CELL_CLEAR  = 2'd0,
        CELL_BORDER = 2'd1,
        CELL_FILL   = 2'd2
    } t_cell;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX,
        ST_RESTORE,
        ST_FLUSH,
        ST_SAVE,
        ST_DRAW,
        ST_RESP
    } t_state;

    typedef struct packed {
        t_req_kind                  req_type;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic [PIX_W-1:0]           pixel_value;
    } t_req;

    typedef struct packed {
        logic [PIX_W-1:0] read_value;
        logic             in_screen;
    } t_res;

    // Sequencer to datapath control word
    typedef struct packed {
        logic                       clr_en;
        logic [FRAME_AW-1:0]        clr_addr;
        logic                       pix_wr;
        logic                       pix_rd;
        logic                       rest_en;
        logic                       save_en;
        logic                       draw_en;
        logic [PATCH_AW-1:0]        cell_k;
        t_cell                      code;
        logic                       resp;
        logic signed [WALK_W-1:0]   cx;
        logic signed [WALK_W-1:0]   cy;
    } t_ctrl;

    // Arrow sprite, two bits per cell, column 0 in the top bits
    localparam logic [2*SPRITE_W-1:0] SHAPE [SPRITE_H] = '{
        24'b01_00_00_00_00_00_00_00_00_00_00_00,
        24'b01_01_00_00_00_00_00_00_00_00_00_00,
        24'b01_10_01_00_00_00_00_00_00_00_00_00,
        24'b01_10_10_01_00_00_00_00_00_00_00_00,
        24'b01_10_10_10_01_00_00_00_00_00_00_00,
        24'b01_10_10_10_10_01_00_00_00_00_00_00,
        24'b01_10_10_10_10_10_01_00_00_00_00_00,
        24'b01_10_10_10_10_10_10_01_00_00_00_00,
        24'b01_10_10_10_10_10_10_10_01_00_00_00,
        24'b01_10_10_10_10_10_10_10_10_01_00_00,
        24'b01_10_10_10_10_10_10_10_10_10_01_00,
        24'b01_10_10_10_10_10_01_01_01_01_01_00,
        24'b01_10_10_01_10_10_01_00_00_00_00_00,
        24'b01_10_01_00_01_10_10_01_00_00_00_00,
        24'b01_01_00_00_01_10_10_01_00_00_00_00,
        24'b01_00_00_00_00_01_10_10_01_00_00_00,
        24'b00_00_00_00_00_01_10_10_01_00_00_00,
        24'b00_00_00_00_00_00_01_01_00_00_00_00,
        24'b00_00_00_00_00_00_00_00_00_00_00_00
    };

    // Sprite lookup for one cell
    function automatic t_cell shape_cell(input logic [ROW_W-1:0] row,
                                         input logic [COL_W-1:0] col);
        logic [2*SPRITE_W-1:0] bits;
        logic [1:0]            raw;
        t_cell                 code;
        bits = '0;
        raw  = '0;
        if (row < ROW_W'(SPRITE_H)) begin
            bits = SHAPE[row];
        end
        if (col < COL_W'(SPRITE_W)) begin
            raw = bits[2*(SPRITE_W-1-int'(col)) +: 2];
        end
        case (raw)
            CELL_BORDER: code = CELL_BORDER;
            CELL_FILL:   code = CELL_FILL;
            default:     code = CELL_CLEAR;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/cso_locate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cso_locate
// Shared address unit: screen clip test and frame index y * width + x.
// ----------------------------------------------------------------------------
module cso_locate (
    input  logic signed [cso_pkg::WALK_W-1:0]  i_x,
    input  logic signed [cso_pkg::WALK_W-1:0]  i_y,
    input  logic [cso_pkg::DIM_W-1:0]          i_w,
    input  logic [cso_pkg::DIM_W-1:0]          i_h,
    output logic                               o_inside,
    output logic [cso_pkg::FRAME_AW-1:0]       o_idx
);

    localparam int PW = cso_pkg::YW + cso_pkg::DIM_W;

    logic [cso_pkg::WALK_W-1:0] ux;
    logic [cso_pkg::WALK_W-1:0] uy;
    logic [PW-1:0]              prod;

    assign ux = i_x;
    assign uy = i_y;

    // Clip against the effective screen (negative coordinates fail the sign test)
    assign o_inside = !ux[cso_pkg::WALK_W-1] && !uy[cso_pkg::WALK_W-1]
                   && (ux < cso_pkg::WALK_W'(i_w)) && (uy < cso_pkg::WALK_W'(i_h));

    // Row-major index; only meaningful when inside
    assign prod  = PW'(uy[cso_pkg::YW-1:0]) * PW'(i_w);
    assign o_idx = cso_pkg::FRAME_AW'(prod + PW'(ux[cso_pkg::XW-1:0]));

endmodule

@@ rtl/cso_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cso_ctrl
// Sequencer: reset clear sweep, pixel access, and the restore / save / draw
// cell walk over the sprite window for a cursor move.
// ----------------------------------------------------------------------------
module cso_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  cso_pkg::t_req     i_req,
    output logic              o_busy,
    output cso_pkg::t_ctrl    o_ctrl
);

    cso_pkg::t_state                    r_state, n_state;
    logic [cso_pkg::FRAME_AW-1:0]       r_clr, n_clr;
    cso_pkg::t_req_kind                 r_kind, n_kind;
    logic signed [cso_pkg::COORD_W-1:0] r_lx, n_lx, r_ly, n_ly;
    logic                               r_pvalid, n_pvalid;
    logic signed [cso_pkg::COORD_W-1:0] r_nx, n_nx, r_ny, n_ny;
    logic signed [cso_pkg::WALK_W-1:0]  r_bx, n_bx, r_cx, n_cx, r_cy, n_cy;
    logic [cso_pkg::COL_W-1:0]          r_col, n_col;
    logic [cso_pkg::ROW_W-1:0]          r_row, n_row;
    logic [cso_pkg::PATCH_AW-1:0]       r_k, n_k;

    logic accept;
    logic walking;
    logic last_cell;
    logic clr_done;

    assign accept    = i_start && (r_state == cso_pkg::ST_IDLE);
    assign walking   = r_state inside {cso_pkg::ST_RESTORE, cso_pkg::ST_SAVE,
                                       cso_pkg::ST_DRAW};
    assign last_cell = (r_k == cso_pkg::PATCH_AW'(cso_pkg::CELLS - 1));
    assign clr_done  = &r_clr;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cso_pkg::ST_CLEAR: begin
                if (clr_done) n_state = cso_pkg::ST_IDLE;
            end
            cso_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (i_req.req_type)
                        cso_pkg::REQ_WRITE,
                        cso_pkg::REQ_READ:  n_state = cso_pkg::ST_PIX;
                        cso_pkg::REQ_MOVE:  n_state = r_pvalid ? cso_pkg::ST_RESTORE
                                                               : cso_pkg::ST_SAVE;
                        default:            n_state = cso_pkg::ST_RESP;
                    endcase
                end
            end
            cso_pkg::ST_PIX:     n_state = cso_pkg::ST_RESP;
            cso_pkg::ST_RESTORE: begin
                if (last_cell) n_state = cso_pkg::ST_FLUSH;
            end
            cso_pkg::ST_FLUSH:   n_state = cso_pkg::ST_SAVE;
            cso_pkg::ST_SAVE: begin
                if (last_cell) n_state = cso_pkg::ST_DRAW;
            end
            cso_pkg::ST_DRAW: begin
                if (last_cell) n_state = cso_pkg::ST_RESP;
            end
            cso_pkg::ST_RESP:    n_state = cso_pkg::ST_IDLE;
            default:             n_state = cso_pkg::ST_IDLE;
        endcase
    end

    // Cursor bookkeeping and cell walker
    always_comb begin
        n_clr    = r_clr;
        n_kind   = r_kind;
        n_lx     = r_lx;
        n_ly     = r_ly;
        n_pvalid = r_pvalid;
        n_nx     = r_nx;
        n_ny     = r_ny;
        n_bx     = r_bx;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_col    = r_col;
        n_row    = r_row;
        n_k      = r_k;
        if (r_state == cso_pkg::ST_CLEAR) begin
            n_clr = r_clr + cso_pkg::FRAME_AW'(1);
        end
        if (accept) begin
            n_kind = i_req.req_type;
            n_nx   = i_req.pos_x;
            n_ny   = i_req.pos_y;
            n_col  = '0;
            n_row  = '0;
            n_k    = '0;
            // A move with a saved patch walks the old window first
            if (i_req.req_type == cso_pkg::REQ_MOVE && r_pvalid) begin
                n_bx = cso_pkg::WALK_W'(r_lx);
                n_cx = cso_pkg::WALK_W'(r_lx);
                n_cy = cso_pkg::WALK_W'(r_ly);
            end else begin
                n_bx = cso_pkg::WALK_W'(i_req.pos_x);
                n_cx = cso_pkg::WALK_W'(i_req.pos_x);
                n_cy = cso_pkg::WALK_W'(i_req.pos_y);
            end
            if (i_req.req_type == cso_pkg::REQ_MOVE) begin
                n_lx     = i_req.pos_x;
                n_ly     = i_req.pos_y;
                n_pvalid = 1'b1;
            end else if (i_req.req_type == cso_pkg::REQ_FORGET) begin
                n_lx     = '1;
                n_ly     = '1;
                n_pvalid = 1'b0;
            end
        end else if (walking) begin
            if (last_cell) begin
                // Next phase always walks the new window
                n_bx  = cso_pkg::WALK_W'(r_nx);
                n_cx  = cso_pkg::WALK_W'(r_nx);
                n_cy  = cso_pkg::WALK_W'(r_ny);
                n_col = '0;
                n_row = '0;
                n_k   = '0;
            end else begin
                n_k = r_k + cso_pkg::PATCH_AW'(1);
                if (r_col == cso_pkg::COL_W'(cso_pkg::SPRITE_W - 1)) begin
                    n_col = '0;
                    n_cx  = r_bx;
                    n_row = r_row + cso_pkg::ROW_W'(1);
                    n_cy  = r_cy + cso_pkg::WALK_W'(1);
                end else begin
                    n_col = r_col + cso_pkg::COL_W'(1);
                    n_cx  = r_cx + cso_pkg::WALK_W'(1);
                end
            end
        end
    end

    // Outputs
    always_comb begin
        o_busy           = (r_state != cso_pkg::ST_IDLE);
        o_ctrl.clr_en    = (r_state == cso_pkg::ST_CLEAR);
        o_ctrl.clr_addr  = r_clr;
        o_ctrl.pix_wr    = (r_state == cso_pkg::ST_PIX) && (r_kind == cso_pkg::REQ_WRITE);
        o_ctrl.pix_rd    = (r_state == cso_pkg::ST_PIX) && (r_kind == cso_pkg::REQ_READ);
        o_ctrl.rest_en   = (r_state == cso_pkg::ST_RESTORE);
        o_ctrl.save_en   = (r_state == cso_pkg::ST_SAVE);
        o_ctrl.draw_en   = (r_state == cso_pkg::ST_DRAW);
        o_ctrl.cell_k    = r_k;
        o_ctrl.code      = cso_pkg::shape_cell(r_row, r_col);
        o_ctrl.resp      = (r_state == cso_pkg::ST_RESP);
        o_ctrl.cx        = r_cx;
        o_ctrl.cy        = r_cy;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cso_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_kind   <= cso_pkg::REQ_WRITE;
            r_lx     <= '1;
            r_ly     <= '1;
            r_pvalid <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_k      <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_kind   <= n_kind;
            r_lx     <= n_lx;
            r_ly     <= n_ly;
            r_pvalid <= n_pvalid;
            r_col    <= n_col;
            r_row    <= n_row;
            r_k      <= n_k;
        end
    end

    // Walker coordinates
    always_ff @(posedge i_clk) begin
        r_nx <= n_nx;
        r_ny <= n_ny;
        r_bx <= n_bx;
        r_cx <= n_cx;
        r_cy <= n_cy;
    end

endmodule

@@ rtl/cursor_sprite_overlay_with_save_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_sprite_overlay_with_save_top
// Software cursor overlay: frame store with host pixel access, cursor moves
// that restore the old background, save the new one and draw the arrow.
// ----------------------------------------------------------------------------
// Accept to o_done: pixel write/read go via ST_PIX, forget straight to ST_RESP;
//   a move walks the 228 sprite cells in ST_RESTORE (saved patch only, then
//   ST_FLUSH), ST_SAVE and ST_DRAW. busy drops the cycle after o_done.
// One frame memory port pair and the shared address unit carry one cell a cycle.
// A new word is taken once busy is low. Reset: clearing pass over the frame
//   store, busy high; config writes taken at any time. Results cannot be stalled.
// ----------------------------------------------------------------------------
module cursor_sprite_overlay_with_save_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  cso_pkg::t_req                   i_req,
    output logic                            o_done,
    output cso_pkg::t_res                   o_res,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cso_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cso_pkg::PIX_W-1:0]       i_cfg_data
);

    cso_pkg::t_ctrl ctrl;

    logic [cso_pkg::DIM_W-1:0]    r_scr_w, r_scr_h;
    logic [cso_pkg::PIX_W-1:0]    r_fill;
    logic [cso_pkg::DIM_W-1:0]    eff_w, eff_h;

    logic                         on_scr;
    logic [cso_pkg::FRAME_AW-1:0] idx;

    logic [cso_pkg::PIX_W-1:0]    r_frame [cso_pkg::FRAME_DEPTH];
    logic [cso_pkg::PIX_W-1:0]    r_frame_q;
    logic [cso_pkg::PIX_W-1:0]    r_patch [cso_pkg::CELLS];
    logic [cso_pkg::PIX_W-1:0]    r_patch_q;
    logic [cso_pkg::PIX_W-1:0]    r_pix;

    logic                         r_pw_frame, r_pw_patch;
    logic [cso_pkg::FRAME_AW-1:0] r_pidx;
    logic [cso_pkg::PATCH_AW-1:0] r_pk;
    logic                         r_res_in, r_res_rd;

    logic                         accept;
    logic                         fr_we, fr_re;
    logic [cso_pkg::FRAME_AW-1:0] fr_waddr;
    logic [cso_pkg::PIX_W-1:0]    fr_wdata;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= cso_pkg::DIM_RESET;
            r_scr_h <= cso_pkg::DIM_RESET;
            r_fill  <= cso_pkg::FILL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cso_pkg::CFG_WIDTH:  r_scr_w <= i_cfg_data[cso_pkg::DIM_W-1:0];
                cso_pkg::CFG_HEIGHT: r_scr_h <= i_cfg_data[cso_pkg::DIM_W-1:0];
                cso_pkg::CFG_FILL:   r_fill  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Oversized screen clamps to the store size
    assign eff_w = (int'(r_scr_w) > cso_pkg::MAX_WIDTH)
                 ? cso_pkg::DIM_W'(cso_pkg::MAX_WIDTH) : r_scr_w;
    assign eff_h = (int'(r_scr_h) > cso_pkg::MAX_HEIGHT)
                 ? cso_pkg::DIM_W'(cso_pkg::MAX_HEIGHT) : r_scr_h;

    cso_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .o_busy  (busy),
        .o_ctrl  (ctrl)
    );

    cso_locate u_locate (
        .i_x      (ctrl.cx),
        .i_y      (ctrl.cy),
        .i_w      (eff_w),
        .i_h      (eff_h),
        .o_inside (on_scr),
        .o_idx    (idx)
    );

    // Pixel data for a write request
    always_ff @(posedge i_clk) begin
        if (accept) r_pix <= i_req.pixel_value;
    end

    // Frame write port select: clear, restore, draw, host write
    always_comb begin
        fr_we    = 1'b0;
        fr_waddr = idx;
        fr_wdata = r_pix;
        if (ctrl.clr_en) begin
            fr_we    = 1'b1;
            fr_waddr = ctrl.clr_addr;
            fr_wdata = '0;
        end else if (r_pw_frame) begin
            fr_we    = 1'b1;
            fr_waddr = r_pidx;
            fr_wdata = r_patch_q;
        end else if (ctrl.draw_en) begin
            fr_we    = on_scr && (ctrl.code != cso_pkg::CELL_CLEAR);
            fr_wdata = (ctrl.code == cso_pkg::CELL_FILL) ? r_fill : cso_pkg::BORDER_COLOR;
        end else if (ctrl.pix_wr) begin
            fr_we    = on_scr;
        end
    end

    assign fr_re = (ctrl.pix_rd || ctrl.save_en) && on_scr;

    // Frame store
    always_ff @(posedge i_clk) begin
        if (fr_we) r_frame[fr_waddr] <= fr_wdata;
        if (fr_re) r_frame_q <= r_frame[idx];
    end

    // Saved background patch
    always_ff @(posedge i_clk) begin
        if (r_pw_patch)   r_patch[r_pk] <= r_frame_q;
        if (ctrl.rest_en) r_patch_q     <= r_patch[ctrl.cell_k];
    end

    // Registered pending write behind each restore and save read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw_frame <= 1'b0;
            r_pw_patch <= 1'b0;
        end else begin
            r_pw_frame <= ctrl.rest_en && on_scr;
            r_pw_patch <= ctrl.save_en && on_scr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= idx;
        r_pk   <= ctrl.cell_k;
    end

    // Result flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_in <= 1'b0;
            r_res_rd <= 1'b0;
        end else if (accept) begin
            r_res_in <= 1'b0;
            r_res_rd <= 1'b0;
        end else if (ctrl.pix_wr || ctrl.pix_rd) begin
            r_res_in <= on_scr;
            r_res_rd <= ctrl.pix_rd && on_scr;
        end
    end

    assign o_done           = ctrl.resp;
    assign o_res.read_value = r_res_rd ? r_frame_q : '0;
    assign o_res.in_screen  = r_res_in;

endmodule

@@ rtl/cso_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cso_checker
// Port-level checks on the cursor overlay handshake and result words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cso_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            busy,
    input  cso_pkg::t_req   i_req,
    input  logic            o_done,
    input  cso_pkg::t_res   o_res
);

    logic acc;
    logic acc_forget;

    assign acc        = start && !busy;
    assign acc_forget = acc && (i_req.req_type == cso_pkg::REQ_FORGET);

    // Result words never come back to back
    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    // A result only shows while a request is in flight
    `ASSERT_IMP(a_done_busy, i_clk, i_rst_n, o_done, busy)
    // An accepted word holds off the next one
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, acc, busy)
    // Forget answers in the following cycle with an empty word
    `ASSERT_NEXT(a_forget_fast, i_clk, i_rst_n, acc_forget, o_done && !o_res.in_screen)
    // Out-of-screen results carry zero data
    `ASSERT_IMP(a_zero_data, i_clk, i_rst_n, o_done && !o_res.in_screen,
                o_res.read_value == '0)

endmodule

bind cursor_sprite_overlay_with_save_top cso_checker u_cso_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_res   (o_res)
);
